@@ rtl/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, sizes and codes of the bounded deque block.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [2:0] MODE_INSERT      = 3'd0;
  localparam logic [2:0] MODE_REMOVE_FRONT = 3'd1;
  localparam logic [2:0] MODE_REMOVE_REAR = 3'd2;
  localparam logic [2:0] MODE_DUMP        = 3'd3;
  localparam logic [2:0] MODE_PEEK        = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } dq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } dq_out_t;

  // commands from controller to datapath
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH,
    OP_REFUSE,
    OP_EMPTY,
    OP_PEEK,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_DUMP_FIRST,
    OP_EMIT_RD,
    OP_DUMP_STEP
  } dq_op_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       empty;
    logic       full;
    logic       dump_end;
  } dq_stat_t;

endpackage

`default_nettype wire

@@ rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words in a ring store; insert at front or
// rear by configuration, remove at either end, peek front, dump all.
//
//   channel  ports                      handshake
//   input    start, busy, in_item       taken when start && !busy
//   result   out_valid, out_item        one-cycle strobe, no back-pressure
//   config   cfg_valid, cfg_ready, cfg_data   taken when valid && ready
//
// Insert, refused insert and any empty case: busy in decode only, result
// registered from it. Remove and peek: busy in decode and emit, since the
// ring store has a registered read port. Dump: busy in decode and the dump
// steps, one word per cycle off the same read port. Reset: synchronous,
// active low, clears head, occupancy and config to insert at front; the
// store is not cleared. The receiver cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire dq_pkg::dq_in_t  in_item,
  output logic                 out_valid,
  output dq_pkg::dq_out_t      out_item,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_data
);
  import dq_pkg::*;

  dq_op_t   op;
  dq_stat_t stat;

  assign cfg_ready = 1'b1;

  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .op    (op)
  );

  dq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

@@ rtl/dq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer of the deque: decodes each accepted word and steps the datapath
// through its write, read and result cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire dq_pkg::dq_stat_t stat,
  output dq_pkg::dq_op_t        op
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_EMIT,
    S_DUMP
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op        = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (stat.mode)
          MODE_INSERT: begin
            op = stat.full ? OP_REFUSE : OP_PUSH;
          end
          MODE_REMOVE_FRONT: begin
            if (stat.empty) begin
              op = OP_EMPTY;
            end else begin
              op        = OP_POP_FRONT;
              state_nxt = S_EMIT;
            end
          end
          MODE_REMOVE_REAR: begin
            if (stat.empty) begin
              op = OP_EMPTY;
            end else begin
              op        = OP_POP_REAR;
              state_nxt = S_EMIT;
            end
          end
          MODE_DUMP: begin
            if (stat.empty) begin
              op = OP_EMPTY;
            end else begin
              op        = OP_DUMP_FIRST;
              state_nxt = S_DUMP;
            end
          end
          MODE_PEEK: begin
            if (stat.empty) begin
              op = OP_EMPTY;
            end else begin
              op        = OP_PEEK;
              state_nxt = S_EMIT;
            end
          end
          default: begin
            // unused modes: no result
            op = OP_NONE;
          end
        endcase
      end
      S_EMIT: begin
        op        = OP_EMIT_RD;
        state_nxt = S_IDLE;
      end
      S_DUMP: begin
        op = OP_DUMP_STEP;
        if (stat.dump_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dq_datapath.sv @@
// ----------------------------------------------------------------------------
// dq_datapath
// Ring store, head and occupancy registers, dump index, configuration bit
// and the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dq_pkg::dq_op_t  op,
  output dq_pkg::dq_stat_t     stat,
  input  wire dq_pkg::dq_in_t  in_item,
  input  wire logic            cfg_valid,
  input  wire logic            cfg_data,
  output logic                 out_valid,
  output dq_pkg::dq_out_t      out_item
);
  import dq_pkg::*;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] WRAP      = SUM_W'(DEPTH);

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(off);
    if (s >= WRAP) begin
      s = s - WRAP;
    end
    return s[PTR_W-1:0];
  endfunction

  logic [31:0]      mem [DEPTH];
  logic [31:0]      rd_data_r;

  logic [2:0]       mode_r;
  logic [31:0]      value_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [PTR_W-1:0] idx_r, idx_nxt;
  logic             ins_front_r;

  logic             out_valid_r, out_valid_nxt;
  dq_out_t          out_item_r, out_item_nxt;

  logic             we, re;
  logic [PTR_W-1:0] wr_addr, rd_addr;
  logic [PTR_W-1:0] head_dec;
  logic [CNT_W-1:0] idx_inc;

  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
  assign idx_inc  = CNT_W'(idx_r) + 1'b1;

  assign stat.mode     = mode_r;
  assign stat.empty    = (occ_r == '0);
  assign stat.full     = (occ_r == FULL_CNT);
  assign stat.dump_end = (idx_inc == occ_r);

  always_comb begin
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    we            = 1'b0;
    re            = 1'b0;
    wr_addr       = head_dec;
    rd_addr       = head_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (op)
      OP_PUSH: begin
        we = 1'b1;
        if (ins_front_r) begin
          wr_addr  = head_dec;
          head_nxt = head_dec;
        end else begin
          wr_addr = wrap_add(head_r, occ_r);
        end
        occ_nxt       = occ_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: ST_OK, data: value_r, last: 1'b1};
      end
      OP_REFUSE: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: ST_OVERFLOW, data: value_r, last: 1'b1};
      end
      OP_EMPTY: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: ST_EMPTY, data: '0, last: 1'b1};
      end
      OP_PEEK: begin
        re = 1'b1;
      end
      OP_POP_FRONT: begin
        re       = 1'b1;
        head_nxt = wrap_add(head_r, CNT_W'(1));
        occ_nxt  = occ_r - 1'b1;
      end
      OP_POP_REAR: begin
        re      = 1'b1;
        rd_addr = wrap_add(head_r, occ_r - 1'b1);
        occ_nxt = occ_r - 1'b1;
      end
      OP_DUMP_FIRST: begin
        re      = 1'b1;
        idx_nxt = '0;
      end
      OP_EMIT_RD: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: ST_OK, data: rd_data_r, last: 1'b1};
      end
      OP_DUMP_STEP: begin
        // emit the word read last cycle, fetch the one after it
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: ST_OK, data: rd_data_r, last: stat.dump_end};
        re            = ~stat.dump_end;
        rd_addr       = wrap_add(head_r, idx_inc);
        idx_nxt       = idx_inc[PTR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= value_r;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      mode_r  <= in_item.mode;
      value_r <= in_item.value;
    end
    idx_r      <= idx_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      occ_r       <= '0;
      ins_front_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        ins_front_r <= cfg_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
